// ===== rtl/core/sgm_pkg.sv =====
`default_nettype none

package sgm_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 4095;

    localparam int PIXEL_W        = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 12;
    localparam int CFG_DATA_W     = 12;
    localparam int CFG_INDEX_W    = 1;

    localparam int OUT_ROW_W    = 12;
    localparam int OUT_COLUMN_W = 10;
    localparam int GRAD_W       = 11;
    localparam int MAG_W        = 8;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

    // smallest frame edge that still leaves an interior
    localparam int MIN_DIM = 3;

    localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

// ===== rtl/core/sobel_gradient_magnitude.sv =====
// Path: a pixel is registered in stage 1 and then in the result register; an interior result
//   leaves with the pixel that completes its window, a border result with its own pixel.
// Throughput: one pixel per cycle while the result register can take it; a pixel that releases
//   both an interior and a border result holds the output register until both have left the single result port.
// Reset: frame size 640 x 480, position (0,0), window zero, pipeline empty. The line memory
//   is not cleared; its contents only reach the output once rows have been written.
`default_nettype none

module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH  = sgm_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = sgm_pkg::DEFAULT_MAX_HEIGHT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   pixel_valid,
    output logic                                        pixel_stall,
    input  wire logic [sgm_pkg::PIXEL_W-1:0]            pixel_value,
    input  wire logic                                   start_of_frame,

    output logic                                        result_valid,
    input  wire logic                                   result_stall,
    output logic [sgm_pkg::OUT_ROW_W-1:0]               out_row,
    output logic [sgm_pkg::OUT_COLUMN_W-1:0]            out_column,
    output logic signed [sgm_pkg::GRAD_W-1:0]           grad_x,
    output logic signed [sgm_pkg::GRAD_W-1:0]           grad_y,
    output logic [sgm_pkg::MAG_W-1:0]                   magnitude,
    output logic                                        is_border,
    output logic                                        last_of_input,

    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [sgm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int PW  = sgm_pkg::PIXEL_W;
    localparam int GW  = sgm_pkg::GRAD_W;
    localparam int FWX = (WW > sgm_pkg::FRAME_WIDTH_W)  ? WW : sgm_pkg::FRAME_WIDTH_W;
    localparam int FHX = (HW > sgm_pkg::FRAME_HEIGHT_W) ? HW : sgm_pkg::FRAME_HEIGHT_W;
    localparam int OCX = (CW > sgm_pkg::OUT_COLUMN_W)   ? CW : sgm_pkg::OUT_COLUMN_W;
    localparam int ORX = (RW > sgm_pkg::OUT_ROW_W)      ? RW : sgm_pkg::OUT_ROW_W;

    // configuration
    logic [sgm_pkg::FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [sgm_pkg::FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [FWX-1:0]                     fw_x;
    logic [FHX-1:0]                     fh_x;
    logic [WW-1:0]                      w_lim;
    logic [HW-1:0]                      h_lim;

    // position
    logic [CW-1:0] col_reg, col_next, c_cur;
    logic [RW-1:0] row_reg, row_next, r_cur;
    logic [WW-1:0] c_x, c_plus;
    logic [HW-1:0] r_x, r_plus;
    logic          int_hit, bor_hit;

    // line memory: upper row in the high byte, middle row in the low byte
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_reg;
    logic            byp_reg;
    logic [2*PW-1:0] byp_data_reg;
    logic [2*PW-1:0] col_data;
    logic [PW-1:0]   upper_px, middle_px;

    // stage 1
    logic          s1_valid_reg, s1_valid_next;
    logic [PW-1:0] s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_int_reg, s1_bor_reg;

    // window, columns 0 and 1 of the three image rows
    logic [PW-1:0] win_reg [3][2];

    // gradient
    logic [PW+1:0] sx_pos, sx_neg, sy_pos, sy_neg;
    logic [GW-1:0] gx, gy, ax_full, ay_full;
    logic [GW-1:0] abs_sum;
    logic [GW-2:0] half_sum;
    logic [PW-1:0] mag;

    // stage 2 / result register
    logic          s2_int_reg, s2_int_next;
    logic          s2_bor_reg, s2_bor_next;
    logic [PW-1:0] s2_pix_reg;
    logic [CW-1:0] s2_col_reg;
    logic [RW-1:0] s2_row_reg;
    logic [GW-1:0] s2_gx_reg, s2_gy_reg;
    logic [PW-1:0] s2_mag_reg;

    logic          s2_ready, s1_adv, pix_fire, out_fire;
    logic [CW-1:0] col_sel;
    logic [RW-1:0] row_sel;
    logic [OCX-1:0] col_x;
    logic [ORX-1:0] row_x;

    // ---------------------------------------------------------------- config
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sgm_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= sgm_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sgm_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[sgm_pkg::FRAME_WIDTH_W-1:0];
                sgm_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[sgm_pkg::FRAME_HEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign fw_x = FWX'(frame_width_reg);
    assign fh_x = FHX'(frame_height_reg);

    always_comb
    begin
        if (fw_x < FWX'(sgm_pkg::MIN_DIM))
            w_lim = WW'(sgm_pkg::MIN_DIM);
        else if (fw_x > FWX'(MAX_WIDTH))
            w_lim = WW'(MAX_WIDTH);
        else
            w_lim = WW'(fw_x);

        if (fh_x < FHX'(sgm_pkg::MIN_DIM))
            h_lim = HW'(sgm_pkg::MIN_DIM);
        else if (fh_x > FHX'(MAX_HEIGHT))
            h_lim = HW'(MAX_HEIGHT);
        else
            h_lim = HW'(fh_x);
    end

    // ---------------------------------------------------------------- handshake
    assign result_valid = s2_int_reg | s2_bor_reg;
    assign out_fire     = result_valid & ~result_stall;
    // a pair of results keeps the register busy until its second result is taken
    assign s2_ready     = ~result_valid | (~result_stall & ~(s2_int_reg & s2_bor_reg));
    assign s1_adv       = s1_valid_reg & s2_ready;
    assign pixel_stall  = s1_valid_reg & ~s2_ready;
    assign pix_fire     = pixel_valid & ~pixel_stall;

    // ---------------------------------------------------------------- position
    always_comb
    begin
        c_cur   = start_of_frame ? '0 : col_reg;
        r_cur   = start_of_frame ? '0 : row_reg;
        c_x     = WW'(c_cur);
        r_x     = HW'(r_cur);
        c_plus  = c_x + WW'(1);
        r_plus  = r_x + HW'(1);

        int_hit = (r_cur >= RW'(2)) && (c_cur >= CW'(2)) && (r_x < h_lim) && (c_x < w_lim);
        bor_hit = (r_cur == '0) || (r_x >= h_lim - HW'(1)) ||
                  (c_cur == '0) || (c_x >= w_lim - WW'(1));

        if (c_plus >= w_lim)
        begin
            col_next = '0;
            row_next = (r_plus >= h_lim) ? '0 : RW'(r_plus);
        end
        else
        begin
            col_next = CW'(c_plus);
            row_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------- line memory
    assign col_data  = byp_reg ? byp_data_reg : rd_reg;
    assign upper_px  = col_data[2*PW-1:PW];
    assign middle_px = col_data[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_col_reg] <= {middle_px, s1_pix_reg};
        if (pix_fire)
            rd_reg <= line_mem[c_cur];
    end

    // forward the column being written when the next beat reads the same address
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            byp_reg      <= s1_adv && (s1_col_reg == c_cur);
            byp_data_reg <= {middle_px, s1_pix_reg};
        end
    end

    // ---------------------------------------------------------------- stage 1
    assign s1_valid_next = pix_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_pix_reg <= pixel_value;
            s1_col_reg <= c_cur;
            s1_row_reg <= r_cur;
            s1_int_reg <= int_hit;
            s1_bor_reg <= bor_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= '0;
                win_reg[k][1] <= '0;
            end
        end
        else if (s1_adv)
        begin
            for (int k = 0; k < 3; k++)
                win_reg[k][0] <= win_reg[k][1];
            win_reg[0][1] <= upper_px;
            win_reg[1][1] <= middle_px;
            win_reg[2][1] <= s1_pix_reg;
        end
    end

    // ---------------------------------------------------------------- gradient
    // window before the shift: column 0 = win col 0, column 1 = win col 1, column 2 = new
    always_comb
    begin
        sx_pos = (PW+2)'(upper_px) + {1'b0, middle_px, 1'b0} + (PW+2)'(s1_pix_reg);
        sx_neg = (PW+2)'(win_reg[0][0]) + {1'b0, win_reg[1][0], 1'b0} +
                 (PW+2)'(win_reg[2][0]);
        sy_pos = (PW+2)'(win_reg[2][0]) + {1'b0, win_reg[2][1], 1'b0} +
                 (PW+2)'(s1_pix_reg);
        sy_neg = (PW+2)'(win_reg[0][0]) + {1'b0, win_reg[0][1], 1'b0} +
                 (PW+2)'(upper_px);

        gx = GW'(sx_pos) - GW'(sx_neg);
        gy = GW'(sy_pos) - GW'(sy_neg);

        ax_full = gx[GW-1] ? (~gx + GW'(1)) : gx;
        ay_full = gy[GW-1] ? (~gy + GW'(1)) : gy;

        abs_sum  = ax_full + ay_full;
        half_sum = abs_sum[GW-1:1];
        mag      = (half_sum > (GW-1)'(sgm_pkg::MAG_MAX)) ? sgm_pkg::MAG_MAX
                                                          : half_sum[PW-1:0];
    end

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        s2_int_next = s2_int_reg;
        s2_bor_next = s2_bor_reg;
        if (out_fire)
        begin
            // interior goes first; drop it and keep the border pending
            if (s2_int_reg)
                s2_int_next = 1'b0;
            else
                s2_bor_next = 1'b0;
        end
        if (s1_adv)
        begin
            s2_int_next = s1_int_reg;
            s2_bor_next = s1_bor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_int_reg <= 1'b0;
            s2_bor_reg <= 1'b0;
        end
        else
        begin
            s2_int_reg <= s2_int_next;
            s2_bor_reg <= s2_bor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_pix_reg <= s1_pix_reg;
            s2_col_reg <= s1_col_reg;
            s2_row_reg <= s1_row_reg;
            s2_gx_reg  <= gx;
            s2_gy_reg  <= gy;
            s2_mag_reg <= mag;
        end
    end

    // ---------------------------------------------------------------- output
    assign col_sel = s2_int_reg ? (s2_col_reg - CW'(1)) : s2_col_reg;
    assign row_sel = s2_int_reg ? (s2_row_reg - RW'(1)) : s2_row_reg;
    assign col_x   = OCX'(col_sel);
    assign row_x   = ORX'(row_sel);

    assign out_column    = col_x[sgm_pkg::OUT_COLUMN_W-1:0];
    assign out_row       = row_x[sgm_pkg::OUT_ROW_W-1:0];
    assign grad_x        = s2_int_reg ? s2_gx_reg : GW'(s2_pix_reg);
    assign grad_y        = s2_int_reg ? s2_gy_reg : GW'(s2_pix_reg);
    assign magnitude     = s2_int_reg ? s2_mag_reg : s2_pix_reg;
    assign is_border     = ~s2_int_reg;
    assign last_of_input = ~(s2_int_reg & s2_bor_reg);

endmodule

`default_nettype wire
